### rtl/core/sbms_pkg.sv
// ----------------------------------------------------------------------------
// sbms_pkg
// Shared types and constants for the multi-stack shared buffer.
// ----------------------------------------------------------------------------
package sbms_pkg;

  // Default sizing of the buffer
  localparam int NumStacksDef  = 8;
  localparam int StoreDepthDef = 64;
  localparam int ValueBitsDef  = 32;

  // Fixed port widths
  localparam int IdxW  = 3;
  localparam int DataW = 32;
  localparam int StatW = 2;

  typedef enum logic [0:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;      // latch the request, launch top and free-head reads
    logic push_commit;  // link the free slot onto the stack
    logic pop_fetch;    // read link and value of the top slot
    logic pop_commit;   // unlink the top slot, return it to the free list
    logic refuse;       // answer full or empty, no state change
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_pop;
    logic push_ok;
    logic pop_ok;
  } stat_t;

endpackage

### rtl/core/shared_buffer_multi_stack.sv
// ----------------------------------------------------------------------------
// shared_buffer_multi_stack
// Several stacks sharing one slot store, free slots kept on a linked list.
//
//   channel   direction  signals                               handshake
//   request   in         cmd_i, stack_index_i, push_value_i    start, busy
//   result    out        status_o, pop_value_o                 res_valid_o
//
// Push: accepted, then looked up and committed; the result is registered as
// the lookup ends. Pop: a read state follows the lookup before the commit;
// it holds the registered read of the top slot's link and value.
// Refused requests (full, empty, bad stack) answer like a push.
// Reset is immediate: fresh slots are tracked by a fill mark, no clearing pass.
// The receiver cannot stall; busy alone holds off new requests.
// ----------------------------------------------------------------------------
module shared_buffer_multi_stack
  import sbms_pkg::*;
#(
  parameter int NUM_STACKS  = NumStacksDef,
  parameter int STORE_DEPTH = StoreDepthDef,
  parameter int VALUE_BITS  = ValueBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    cmd_i,
  input  logic [IdxW-1:0]         stack_index_i,
  input  logic signed [DataW-1:0] push_value_i,
  output logic                    res_valid_o,
  output logic [StatW-1:0]        status_o,
  output logic signed [DataW-1:0] pop_value_o
);

  ctrl_t ctrl;
  stat_t stat;

  sbms_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy)
  );

  sbms_dpath #(
    .NUM_STACKS  (NUM_STACKS),
    .STORE_DEPTH (STORE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .cmd_i         (cmd_i),
    .stack_index_i (stack_index_i),
    .push_value_i  (push_value_i),
    .res_valid_o   (res_valid_o),
    .status_o      (status_o),
    .pop_value_o   (pop_value_o)
  );

endmodule

### rtl/core/sbms_ram.sv
// ----------------------------------------------------------------------------
// sbms_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sbms_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/sbms_ctrl.sv
// ----------------------------------------------------------------------------
// sbms_ctrl
// Request sequencer: lookup, then commit or refuse; pops take an extra read.
// ----------------------------------------------------------------------------
module sbms_ctrl
  import sbms_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_POP_RD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctrl_o.capture = 1'b1;
          state_d        = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (stat_i.is_pop) begin
          if (stat_i.pop_ok) begin
            ctrl_o.pop_fetch = 1'b1;
            state_d          = S_POP_RD;
          end else begin
            ctrl_o.refuse = 1'b1;
            state_d       = S_IDLE;
          end
        end else begin
          if (stat_i.push_ok) begin
            ctrl_o.push_commit = 1'b1;
          end else begin
            ctrl_o.refuse = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_POP_RD: begin
        ctrl_o.pop_commit = 1'b1;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // A pop that passed its check always goes on to commit
  a_fetch_then_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.pop_fetch |=> ctrl_o.pop_commit)
    else $error("pop fetch not followed by commit");

  // Every lookup ends the request or moves to the pop read
  a_lookup_resolves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOKUP) |->
      $onehot({ctrl_o.push_commit, ctrl_o.pop_fetch, ctrl_o.refuse}))
    else $error("lookup did not resolve");

  a_start_ignored_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !ctrl_o.capture)
    else $error("capture while busy");

endmodule

### rtl/core/sbms_dpath.sv
// ----------------------------------------------------------------------------
// sbms_dpath
// Value, link and top stores, free-list head and the result register.
// ----------------------------------------------------------------------------
module sbms_dpath
  import sbms_pkg::*;
#(
  parameter int NUM_STACKS  = NumStacksDef,
  parameter int STORE_DEPTH = StoreDepthDef,
  parameter int VALUE_BITS  = ValueBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_t                   ctrl_i,
  output stat_t                   stat_o,
  input  logic                    cmd_i,
  input  logic [IdxW-1:0]         stack_index_i,
  input  logic signed [DataW-1:0] push_value_i,
  output logic                    res_valid_o,
  output logic [StatW-1:0]        status_o,
  output logic signed [DataW-1:0] pop_value_o
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PW = $clog2(STORE_DEPTH + 1);   // slot pointer incl. end marker
  localparam int TW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [PW-1:0] EndMark = PW'(STORE_DEPTH);

  // Request registers
  cmd_e                  cmd_q;
  logic [IdxW-1:0]       idx_q;
  logic [VALUE_BITS-1:0] val_q;

  // List state
  logic [PW-1:0]         free_head_q;
  logic [PW-1:0]         hw_q;          // slots at or above never written
  logic [NUM_STACKS-1:0] top_vld_q;
  logic [PW-1:0]         slot_q;

  // Link read bookkeeping for slots never written
  logic                  fresh_q;
  logic [PW-1:0]         nxt_q;

  // Result registers
  logic                    res_valid_q;
  status_e                 status_q;
  logic signed [DataW-1:0] pop_value_q;

  // Store ports
  logic [PW-1:0]         top_rdata, top_wdata, link_rdata, link_wdata;
  logic [TW-1:0]         top_raddr, top_waddr;
  logic                  top_we, link_we;
  logic [PW-1:0]         link_raddr, link_waddr;
  logic [VALUE_BITS-1:0] val_rdata;

  logic          idx_ok, vld_bit;
  logic [PW-1:0] top_cur, link_eff;

  assign idx_ok   = int'(idx_q) < NUM_STACKS;
  assign vld_bit  = idx_ok && top_vld_q[TW'(idx_q)];
  assign top_cur  = vld_bit ? top_rdata : EndMark;
  assign link_eff = fresh_q ? nxt_q : link_rdata;

  assign stat_o.is_pop  = (cmd_q == CMD_POP);
  assign stat_o.push_ok = idx_ok && (free_head_q < EndMark);
  assign stat_o.pop_ok  = idx_ok && (top_cur < EndMark);

  // Read addresses
  assign top_raddr  = ctrl_i.capture ? TW'(stack_index_i) : TW'(idx_q);
  assign link_raddr = ctrl_i.capture ? free_head_q : top_cur;

  // Writes: a push links the free slot on top, a pop returns the top slot
  assign top_we     = ctrl_i.push_commit || ctrl_i.pop_commit;
  assign top_waddr  = TW'(idx_q);
  assign top_wdata  = ctrl_i.push_commit ? free_head_q : link_eff;
  assign link_we    = ctrl_i.push_commit || ctrl_i.pop_commit;
  assign link_waddr = ctrl_i.push_commit ? free_head_q : slot_q;
  assign link_wdata = ctrl_i.push_commit ? top_cur : free_head_q;

  sbms_ram #(.Width(PW), .Depth(NUM_STACKS)) u_tops (
    .clk_i   (clk_i),
    .we_i    (top_we),
    .waddr_i (top_waddr),
    .wdata_i (top_wdata),
    .raddr_i (top_raddr),
    .rdata_o (top_rdata)
  );

  sbms_ram #(.Width(PW), .Depth(STORE_DEPTH)) u_links (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr[AW-1:0]),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr[AW-1:0]),
    .rdata_o (link_rdata)
  );

  sbms_ram #(.Width(VALUE_BITS), .Depth(STORE_DEPTH)) u_values (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.push_commit),
    .waddr_i (free_head_q[AW-1:0]),
    .wdata_i (val_q),
    .raddr_i (top_cur[AW-1:0]),
    .rdata_o (val_rdata)
  );

  // Request capture and link read tracking, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= cmd_e'(cmd_i);
      idx_q <= stack_index_i;
      val_q <= VALUE_BITS'(push_value_i);
    end
    if (ctrl_i.pop_fetch) begin
      slot_q <= top_cur;
    end
    fresh_q <= (link_raddr >= hw_q);
    nxt_q   <= link_raddr + PW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      hw_q        <= '0;
      top_vld_q   <= '0;
      res_valid_q <= 1'b0;
      status_q    <= ST_OK;
      pop_value_q <= '0;
    end else begin
      res_valid_q <= ctrl_i.push_commit || ctrl_i.pop_commit || ctrl_i.refuse;
      if (ctrl_i.push_commit) begin
        free_head_q            <= link_eff;
        top_vld_q[TW'(idx_q)]  <= 1'b1;
        if (free_head_q == hw_q) begin
          hw_q <= hw_q + PW'(1);
        end
        status_q    <= ST_OK;
        pop_value_q <= '0;
      end else if (ctrl_i.pop_commit) begin
        free_head_q <= slot_q;
        status_q    <= ST_OK;
        pop_value_q <= DataW'($signed(val_rdata));
      end else if (ctrl_i.refuse) begin
        status_q    <= stat_o.is_pop ? ST_EMPTY : ST_FULL;
        pop_value_q <= '0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign status_o    = status_q;
  assign pop_value_o = pop_value_q;

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl_i.capture, ctrl_i.push_commit, ctrl_i.pop_fetch,
              ctrl_i.pop_commit, ctrl_i.refuse}))
    else $error("conflicting datapath commands");

  // Free head is a recycled slot, the first fresh slot, or the end marker
  a_head_below_hw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_head_q <= hw_q) && (hw_q <= EndMark))
    else $error("free head beyond fill mark");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && status_q != ST_OK) |-> (pop_value_q == '0))
    else $error("refused request carries a value");

  a_push_bumps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push_commit |=> (free_head_q != $past(free_head_q)))
    else $error("push did not advance free head");

endmodule
